>>> rtl/nps_pkg.sv
package nps_pkg;

  localparam int unsigned NumPadsDefault = 4;
  localparam int unsigned PadSlots       = 4;
  localparam logic [4:0]  PhaseLast      = 5'(24 - 1);
  localparam logic [2:0]  TopBit         = 3'd7;

  typedef enum logic [1:0] {
    ActStart = 2'd0,
    ActTick  = 2'd1,
    ActQuery = 2'd2,
    ActNop   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    GrpClockHigh = 2'd0,
    GrpClockLow  = 2'd1,
    GrpSample    = 2'd2
  } phase_grp_e;

  typedef struct packed {
    logic       latch_pin;
    logic       clock_pin;
    logic [1:0] mux_select;
    logic       scan_busy;
    logic       byte_done;
    logic [1:0] status_pad;
    logic [7:0] pressed_mask;
    logic       pad_connected;
    logic [3:0] last_button;
  } result_t;

  // Position of a phase inside its clock-high, clock-low, sample group.
  function automatic phase_grp_e phase_group(input logic [4:0] phase);
    phase_grp_e grp;
    case (phase) inside
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24, 5'd27, 5'd30:
        grp = GrpClockHigh;
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22, 5'd25, 5'd28, 5'd31:
        grp = GrpClockLow;
      default:
        grp = GrpSample;
    endcase
    return grp;
  endfunction

  // Button code of the highest-priority set bit: bit 0 (Right) wins.
  function automatic logic [3:0] button_code(input logic [7:0] fresh);
    logic [3:0] code;
    code = 4'd0;
    for (int b = 7; b >= 0; b--) begin
      if (fresh[b]) begin
        code = 4'(8 - b);
      end
    end
    return code;
  endfunction

endpackage

>>> rtl/nps_in_if.sv
interface nps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       serial_in;
  logic [1:0] query_pad;
  logic       clear_last;

  modport source (output valid, action, serial_in, query_pad, clear_last, input ready);
  modport sink   (input valid, action, serial_in, query_pad, clear_last, output ready);
endinterface

>>> rtl/nps_out_if.sv
interface nps_out_if;
  logic       valid;
  logic       ready;
  logic       latch_pin;
  logic       clock_pin;
  logic [1:0] mux_select;
  logic       scan_busy;
  logic       byte_done;
  logic [1:0] status_pad;
  logic [7:0] pressed_mask;
  logic       pad_connected;
  logic [3:0] last_button;

  modport source (output valid, latch_pin, clock_pin, mux_select, scan_busy, byte_done,
                  status_pad, pressed_mask, pad_connected, last_button, input ready);
  modport sink   (input valid, latch_pin, clock_pin, mux_select, scan_busy, byte_done,
                  status_pad, pressed_mask, pad_connected, last_button, output ready);
endinterface

>>> rtl/nes_pad_scanner.sv
// The result word of an accepted input word is registered and shows in the next cycle.
// Throughput: one word per cycle; the result register frees as soon as it is
// taken, so input ready drops only while a result sits unconsumed.
// Reset (rst_ni low, asynchronous): scan idle at phase 0, pad 0 selected,
// latch and clock low, all pads disconnected with no buttons recorded.
module nes_pad_scanner
  import nps_pkg::*;
#(
  parameter int unsigned NUM_PADS = NumPadsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nps_in_if.sink       in_i,
  nps_out_if.source    out_o
);

  // Select code at which the pad index wraps back to zero.
  localparam logic [1:0] LastPad = 2'(NUM_PADS - 1);

  // Scan sequencer state.
  logic [4:0] phase_q, phase_d;
  logic [2:0] bit_idx_q, bit_idx_d;
  logic [7:0] shift_q, shift_d;
  logic       running_q, running_d;
  logic [1:0] cur_pad_q, cur_pad_d;
  logic       latch_q, latch_d;
  logic       clock_q, clock_d;

  // Per-pad status file.
  logic [7:0] pressed_q [PadSlots];
  logic [7:0] pressed_d [PadSlots];
  logic       online_q  [PadSlots];
  logic       online_d  [PadSlots];
  logic [3:0] last_q    [PadSlots];
  logic [3:0] last_d    [PadSlots];

  // Result register.
  logic    out_valid_q;
  result_t out_q, out_d;

  logic       accept;
  action_e    act;
  logic [7:0] shift_nx;
  logic [7:0] now_mask;
  logic [7:0] fresh;
  logic       done;

  // Take a new word whenever the result register is empty or being drained.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign act        = action_e'(in_i.action);

  // Sampled byte including this tick's bit, MSB first.
  always_comb begin
    shift_nx = shift_q;
    shift_nx[TopBit - bit_idx_q] = shift_q[TopBit - bit_idx_q] | in_i.serial_in;
  end

  // Active-low pad byte turned into a pressed mask, and the newly pressed buttons.
  assign now_mask = ~shift_nx;
  assign fresh    = now_mask & ~pressed_q[cur_pad_q];

  always_comb begin
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    running_d = running_q;
    cur_pad_d = cur_pad_q;
    latch_d   = latch_q;
    clock_d   = clock_q;
    pressed_d = pressed_q;
    online_d  = online_q;
    last_d    = last_q;
    done      = 1'b0;

    out_d               = '0;

    if (accept) begin
      case (act)
        ActStart: begin
          // Advance the pad index; a sequence already running keeps going.
          cur_pad_d = (cur_pad_q >= LastPad) ? 2'd0 : cur_pad_q + 2'd1;
          running_d = 1'b1;
        end
        ActTick: begin
          if (running_q) begin
            if (phase_q == 5'd0) begin
              latch_d = 1'b1;
            end else if (phase_q == 5'd1) begin
              latch_d = 1'b0;
            end else begin
              case (phase_group(phase_q))
                GrpClockHigh: clock_d = 1'b1;
                GrpClockLow:  clock_d = 1'b0;
                default: begin
                  shift_d   = shift_nx;
                  bit_idx_d = bit_idx_q + 3'd1;
                end
              endcase
            end
            phase_d = phase_q + 5'd1;

            // Last phase: hand the byte to the selected pad and rearm.
            if (phase_q == PhaseLast) begin
              running_d = 1'b0;
              phase_d   = '0;
              bit_idx_d = '0;
              shift_d   = '0;
              done      = 1'b1;
              if (shift_nx == 8'd0) begin
                // Silent line: drop the pad only if it was up.
                if (online_q[cur_pad_q]) begin
                  pressed_d[cur_pad_q] = '0;
                  online_d[cur_pad_q]  = 1'b0;
                end
              end else begin
                if (fresh != 8'd0) begin
                  last_d[cur_pad_q] = button_code(fresh);
                end
                pressed_d[cur_pad_q] = now_mask;
                online_d[cur_pad_q]  = 1'b1;
              end
            end
          end
        end
        ActQuery: begin
          out_d.status_pad    = in_i.query_pad;
          out_d.pressed_mask  = pressed_q[in_i.query_pad];
          out_d.pad_connected = online_q[in_i.query_pad];
          out_d.last_button   = last_q[in_i.query_pad];
          if (in_i.clear_last) begin
            last_d[in_i.query_pad] = '0;
          end
        end
        default: begin
        end
      endcase
    end

    out_d.latch_pin  = latch_d;
    out_d.clock_pin  = clock_d;
    out_d.mux_select = cur_pad_d;
    out_d.scan_busy  = running_d;
    out_d.byte_done  = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      bit_idx_q   <= '0;
      shift_q     <= '0;
      running_q   <= 1'b0;
      cur_pad_q   <= '0;
      latch_q     <= 1'b0;
      clock_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < PadSlots; i++) begin
        pressed_q[i] <= '0;
        online_q[i]  <= 1'b0;
        last_q[i]    <= '0;
      end
    end else begin
      phase_q   <= phase_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      running_q <= running_d;
      cur_pad_q <= cur_pad_d;
      latch_q   <= latch_d;
      clock_q   <= clock_d;
      pressed_q <= pressed_d;
      online_q  <= online_d;
      last_q    <= last_d;
      // Hold the result until taken; load a new one on every accepted word.
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: loaded only with an accepted word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.latch_pin     = out_q.latch_pin;
  assign out_o.clock_pin     = out_q.clock_pin;
  assign out_o.mux_select    = out_q.mux_select;
  assign out_o.scan_busy     = out_q.scan_busy;
  assign out_o.byte_done     = out_q.byte_done;
  assign out_o.status_pad    = out_q.status_pad;
  assign out_o.pressed_mask  = out_q.pressed_mask;
  assign out_o.pad_connected = out_q.pad_connected;
  assign out_o.last_button   = out_q.last_button;

endmodule
